// ----- rtl/core/urs_pkg.sv -----
// urs_pkg: shared types and constants for the ultrasonic ranger sequencer
// no dependencies; imported by every module in rtl/core
package urs_pkg;

	localparam int TRIG_W       = 3;
	localparam int IDX_W        = 2;
	localparam int DIST_W       = 15;
	localparam int TICKS_W      = 8;
	localparam int ECHO_W       = 3;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	// register map (word index taken from paddr[2])
	localparam logic REG_TRIGGER_TICKS = 1'b0;

	localparam logic [TICKS_W-1:0] TRIGGER_TICKS_RST = 8'd9;

	// count*16/58 == count*8/29, done as (count*8) * ceil(2^32/29) >> 32
	// exact for count*8 below 2^32/13, i.e. counters up to 24 bits
	localparam int                   RECIP_W     = 28;
	localparam int                   RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0]   RECIP_29    = 28'd148102321;
	localparam logic [DIST_W-1:0]    DIST_MAX    = 15'd32767;

	typedef struct packed {
		logic [TRIG_W-1:0] trigger_levels;
		logic              distance_valid;
		logic [IDX_W-1:0]  sensor_index;
		logic [DIST_W-1:0] distance_q4;
	} res_t;

endpackage

// ----- rtl/core/urs_cfg.sv -----
// urs_cfg: APB register file holding trigger_ticks
// depends on urs_pkg
module urs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [urs_pkg::PADDR_W-1:0]   paddr,
	input  logic [urs_pkg::PDATA_W-1:0]   pwdata,
	output logic [urs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [urs_pkg::TICKS_W-1:0]   trigger_ticks
);
	import urs_pkg::*;

	logic [TICKS_W-1:0] trigger_ticks_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TRIGGER_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= TRIGGER_TICKS_RST;
		end else if (wr_en) begin
			trigger_ticks_q <= pwdata[TICKS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TRIGGER_TICKS) begin
			prdata = {{(PDATA_W-TICKS_W){1'b0}}, trigger_ticks_q};
		end
	end

	assign trigger_ticks = trigger_ticks_q;

endmodule

// ----- rtl/core/urs_dist.sv -----
// urs_dist: echo count to centimetres (unsigned Q.4) by reciprocal multiply
// depends on urs_pkg
module urs_dist #(
	parameter int ECHO_COUNT_BITS = 16
) (
	input  logic [ECHO_COUNT_BITS-1:0]   echo_count,
	output logic [urs_pkg::DIST_W-1:0]   distance_q4
);
	import urs_pkg::*;

	localparam int NUM_W  = ECHO_COUNT_BITS + 3;
	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int Q_W    = PROD_W - RECIP_SHIFT;

	logic [NUM_W-1:0]  num;
	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0]    quot;

	assign num  = {echo_count, 3'b000};
	assign prod = PROD_W'(num) * PROD_W'(RECIP_29);
	assign quot = prod[PROD_W-1:RECIP_SHIFT];

	generate
		if (Q_W > DIST_W) begin : g_sat
			assign distance_q4 = (|quot[Q_W-1:DIST_W]) ? DIST_MAX : quot[DIST_W-1:0];
		end else begin : g_nosat
			assign distance_q4 = DIST_W'(quot);
		end
	endgenerate

endmodule

// ----- rtl/core/urs_seq.sv -----
// urs_seq: round-robin trigger / echo sequencer, one tick per step
// depends on urs_pkg; distance comes from urs_dist
module urs_seq #(
	parameter int NUM_SENSORS     = 3,
	parameter int ECHO_COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [urs_pkg::ECHO_W-1:0]    echo_levels,
	input  logic [urs_pkg::TICKS_W-1:0]   trigger_ticks,
	input  logic [urs_pkg::DIST_W-1:0]    distance_q4,
	output logic [ECHO_COUNT_BITS-1:0]    echo_count,
	output urs_pkg::res_t                 res
);
	import urs_pkg::*;

	typedef enum logic [2:0] {
		PH_TRIG_HIGH,
		PH_TRIG_LOW,
		PH_ECHO_WAIT,
		PH_ECHO_HIGH,
		PH_REPORT
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [IDX_W-1:0]           sensor_q, sensor_d;
	logic [TICKS_W-1:0]         trig_cnt_q, trig_cnt_d, trig_cnt_inc;
	logic [ECHO_COUNT_BITS-1:0] echo_cnt_q, echo_cnt_d;
	logic [TRIG_W-1:0]          trig_pins_q, trig_pins_d;
	logic                       echo_bit;
	logic [TRIG_W-1:0]          mask;

	// sensors with no pin: echo reads low, no trigger bit
	always_comb begin
		echo_bit = 1'b0;
		mask     = '0;
		if (sensor_q < IDX_W'(TRIG_W)) begin
			echo_bit = echo_levels[sensor_q];
			mask     = TRIG_W'(1) << sensor_q;
		end
	end

	assign trig_cnt_inc = trig_cnt_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		sensor_d    = sensor_q;
		trig_cnt_d  = trig_cnt_q;
		echo_cnt_d  = echo_cnt_q;
		trig_pins_d = trig_pins_q;
		res         = '0;
		case (phase_q)
			PH_TRIG_HIGH: begin
				trig_pins_d = trig_pins_q | mask;
				trig_cnt_d  = trig_cnt_inc;
				if (trig_cnt_inc == trigger_ticks) begin
					trig_cnt_d = '0;
					phase_d    = PH_TRIG_LOW;
				end
			end
			PH_TRIG_LOW: begin
				trig_pins_d = trig_pins_q & ~mask;
				phase_d     = PH_ECHO_WAIT;
			end
			PH_ECHO_WAIT: begin
				if (echo_bit) begin
					phase_d = PH_ECHO_HIGH;
				end
			end
			PH_ECHO_HIGH: begin
				if (echo_bit) begin
					if (echo_cnt_q != '1) begin
						echo_cnt_d = echo_cnt_q + 1'b1;
					end
				end else begin
					phase_d = PH_REPORT;
				end
			end
			PH_REPORT: begin
				res.distance_valid = 1'b1;
				res.sensor_index   = sensor_q;
				res.distance_q4    = distance_q4;
				echo_cnt_d         = '0;
				sensor_d           = (sensor_q == IDX_W'(NUM_SENSORS - 1)) ? '0
				                     : sensor_q + 1'b1;
				phase_d            = PH_TRIG_HIGH;
			end
			default: begin
				phase_d = PH_TRIG_HIGH;
			end
		endcase
		res.trigger_levels = trig_pins_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TRIG_HIGH;
			sensor_q    <= '0;
			trig_cnt_q  <= '0;
			echo_cnt_q  <= '0;
			trig_pins_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			sensor_q    <= sensor_d;
			trig_cnt_q  <= trig_cnt_d;
			echo_cnt_q  <= echo_cnt_d;
			trig_pins_q <= trig_pins_d;
		end
	end

	assign echo_count = echo_cnt_q;

endmodule

// ----- rtl/core/ultrasonic_ranger_sequencer_top.sv -----
// ultrasonic_ranger_sequencer_top: tick input register, sequencer, result register
// depends on urs_pkg, urs_cfg, urs_seq, urs_dist
//
// usage
//  - one input item per microsecond tick on in_valid/in_ready, carrying the
//    echo pin levels (bit i is sensor i)
//  - one result item per input item on out_valid/out_ready: trigger pin
//    levels after the tick, plus distance_valid, sensor_index and
//    distance_q4 on the tick that closes a measurement (zero otherwise)
//  - out_valid rises after the input accept edge: the tick register takes the
//    item, then the sequencer writes the result register once the slot is free
//  - throughput is one item per cycle while the receiver keeps taking results;
//    the sequencer next state and the distance multiply (one 19x28 reciprocal
//    product at the default counter width) are combinational
//  - a new item is taken while a result waits, as long as the tick register
//    can move on or is empty
//  - when the receiver stalls, the result register holds its item and the
//    tick register holds the next one; in_ready drops only when both are full
//  - reset: sequencer starts on sensor 0 in the trigger-high phase with all
//    trigger pins low and counts cleared; trigger_ticks returns to 9
//  - user writes trigger_ticks over APB at address 0 only while idle, unchecked
module ultrasonic_ranger_sequencer_top #(
	parameter int NUM_SENSORS     = 3,
	parameter int ECHO_COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// tick items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [urs_pkg::ECHO_W-1:0]    echo_levels,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [urs_pkg::TRIG_W-1:0]    trigger_levels,
	output logic                          distance_valid,
	output logic [urs_pkg::IDX_W-1:0]     sensor_index,
	output logic [urs_pkg::DIST_W-1:0]    distance_q4,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [urs_pkg::PADDR_W-1:0]   paddr,
	input  logic [urs_pkg::PDATA_W-1:0]   pwdata,
	output logic [urs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import urs_pkg::*;

	logic                       valid_s1;
	logic [ECHO_W-1:0]          echo_s1;
	logic                       out_valid_q;
	res_t                       out_res_q;
	res_t                       res;
	logic                       out_free;
	logic                       step;
	logic [TICKS_W-1:0]         trigger_ticks;
	logic [ECHO_COUNT_BITS-1:0] echo_count;
	logic [DIST_W-1:0]          dist_q4;

	// result slot frees when empty or being taken this cycle
	assign out_free = !out_valid_q || out_ready;
	// a tick moves through the sequencer when its result has a place to go
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	urs_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.trigger_ticks (trigger_ticks)
	);

	urs_dist #(
		.ECHO_COUNT_BITS (ECHO_COUNT_BITS)
	) u_dist (
		.echo_count  (echo_count),
		.distance_q4 (dist_q4)
	);

	urs_seq #(
		.NUM_SENSORS     (NUM_SENSORS),
		.ECHO_COUNT_BITS (ECHO_COUNT_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.echo_levels   (echo_s1),
		.trigger_ticks (trigger_ticks),
		.distance_q4   (dist_q4),
		.echo_count    (echo_count),
		.res           (res)
	);

	// tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			echo_s1 <= echo_levels;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign trigger_levels = out_res_q.trigger_levels;
	assign distance_valid = out_res_q.distance_valid;
	assign sensor_index   = out_res_q.sensor_index;
	assign distance_q4    = out_res_q.distance_q4;

endmodule

// ----- tb/ranger_checker.sv -----
// ranger_checker: tracks the ranger sequencer tick by tick and checks every result item
// depends on urs_pkg; watches the tick, result and APB channels of the top level
module ranger_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [urs_pkg::ECHO_W-1:0]  echo_levels,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [urs_pkg::TRIG_W-1:0]  trigger_levels,
	input  logic                        distance_valid,
	input  logic [urs_pkg::IDX_W-1:0]   sensor_index,
	input  logic [urs_pkg::DIST_W-1:0]  distance_q4,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [urs_pkg::PADDR_W-1:0] paddr,
	input  logic [urs_pkg::PDATA_W-1:0] pwdata,
	output int                          pending,
	output logic [urs_pkg::IDX_W-1:0]   sensor_now,
	output int                          mismatch_total
);
	import urs_pkg::*;

	localparam int          RANGER_COUNT = 3;
	localparam logic [15:0] ECHO_CEIL    = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_TRIG_HIGH,
		PH_TRIG_LOW,
		PH_ECHO_WAIT,
		PH_ECHO_HIGH,
		PH_REPORT
	} ranger_phase_t;

	ranger_phase_t      phase;
	logic [IDX_W-1:0]   sensor;
	logic [TICKS_W-1:0] ticks_cfg;
	logic [TICKS_W-1:0] pulse_cnt;
	logic [15:0]        echo_cnt;
	logic [TRIG_W-1:0]  pins;
	res_t               tick_results_due[$];
	res_t               want;
	res_t               got;

	// one tick of the sequencer: returns the result item the tick produces
	task automatic advance_tick(input logic [ECHO_W-1:0] echo, output res_t r);
		int   dist_v;
		logic hit;
		r = '0;
		hit = (sensor < RANGER_COUNT) && echo[sensor];
		case (phase)
			PH_TRIG_LOW: begin
				if (sensor < RANGER_COUNT)
					pins[sensor] = 1'b0;
				phase = PH_ECHO_WAIT;
			end
			PH_ECHO_WAIT: begin
				if (hit)
					phase = PH_ECHO_HIGH;
			end
			PH_ECHO_HIGH: begin
				if (hit) begin
					if (echo_cnt != ECHO_CEIL)
						echo_cnt = echo_cnt + 1'b1;
				end else begin
					phase = PH_REPORT;
				end
			end
			PH_REPORT: begin
				dist_v = (int'(echo_cnt) * 16) / 58;
				if (dist_v > int'(DIST_MAX))
					dist_v = int'(DIST_MAX);
				r.distance_valid = 1'b1;
				r.sensor_index   = sensor;
				r.distance_q4    = dist_v[DIST_W-1:0];
				echo_cnt = '0;
				sensor   = (sensor == RANGER_COUNT - 1) ? '0 : sensor + 1'b1;
				phase    = PH_TRIG_HIGH;
			end
			default: begin
				if (sensor < RANGER_COUNT)
					pins[sensor] = 1'b1;
				pulse_cnt = pulse_cnt + 1'b1;
				if (pulse_cnt == ticks_cfg) begin
					pulse_cnt = '0;
					phase     = PH_TRIG_LOW;
				end
			end
		endcase
		r.trigger_levels = pins;
	endtask

	task automatic report_field(input string field, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			mismatch_total++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, field, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase     = PH_TRIG_HIGH;
			sensor    = '0;
			ticks_cfg = TRIGGER_TICKS_RST;
			pulse_cnt = '0;
			echo_cnt  = '0;
			pins      = '0;
			mismatch_total = 0;
			tick_results_due.delete();
			pending    <= 0;
			sensor_now <= '0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_TRIGGER_TICKS)
				ticks_cfg = pwdata[TICKS_W-1:0];
			if (out_valid && out_ready) begin
				got = {trigger_levels, distance_valid, sensor_index, distance_q4};
				if (tick_results_due.size() == 0) begin
					mismatch_total++;
					$display("%0t: result item with no tick pending, expected none, actual %h",
						$time, got);
				end else begin
					want = tick_results_due.pop_front();
					report_field("trigger_levels", 32'(want.trigger_levels), 32'(got.trigger_levels));
					report_field("distance_valid", 32'(want.distance_valid), 32'(got.distance_valid));
					report_field("sensor_index", 32'(want.sensor_index), 32'(got.sensor_index));
					report_field("distance_q4", 32'(want.distance_q4), 32'(got.distance_q4));
				end
			end
			if (in_valid && in_ready) begin
				advance_tick(echo_levels, want);
				tick_results_due.push_back(want);
			end
			pending    <= tick_results_due.size();
			sensor_now <= sensor;
		end
	end

endmodule

// ----- tb/testbench.sv -----
// testbench: stimulus and verdict for ultrasonic_ranger_sequencer_top
// depends on urs_pkg, the rtl/core sources and tb/ranger_checker.sv
module testbench;
	import urs_pkg::*;

	// cycles with no accepted item before the run is declared hung
	localparam int IDLE_LIMIT       = 2000;
	// minimum tick items per random configuration phase
	localparam int PHASE_BUDGET     = 40;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic [ECHO_W-1:0]  echo_levels = '0;
	logic               out_ready   = 1'b0;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [PADDR_W-1:0] paddr       = '0;
	logic [PDATA_W-1:0] pwdata      = '0;

	logic               in_ready;
	logic               out_valid;
	logic [TRIG_W-1:0]  trigger_levels;
	logic               distance_valid;
	logic [IDX_W-1:0]   sensor_index;
	logic [DIST_W-1:0]  distance_q4;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int                 pending;
	logic [IDX_W-1:0]   sensor_now;
	int                 mismatch_total;

	// stimulus bookkeeping: which ranger the next echo pulse is aimed at
	logic [IDX_W-1:0]   ranger;
	logic [TICKS_W-1:0] ticks_now;
	logic               bursty;
	int                 burst_left;
	int                 ticks_sent;

	// receiver pattern state
	int                 rx_cycles   = 0;
	int                 hold_left   = 0;
	int                 rx_mode     = 0;
	int                 rx_mode_left = 0;
	int                 idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ultrasonic_ranger_sequencer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.echo_levels    (echo_levels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.trigger_levels (trigger_levels),
		.distance_valid (distance_valid),
		.sensor_index   (sensor_index),
		.distance_q4    (distance_q4),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	ranger_checker ranger_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.echo_levels    (echo_levels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.trigger_levels (trigger_levels),
		.distance_valid (distance_valid),
		.sensor_index   (sensor_index),
		.distance_q4    (distance_q4),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pending        (pending),
		.sensor_now     (sensor_now),
		.mismatch_total (mismatch_total)
	);

	// receiver: runs in modes (always ready, random stalls, fixed pattern),
	// with long hold-offs, both periodic and now and then at random, so
	// the tick and result registers fill and in_ready drops
	always @(posedge clk) begin
		rx_cycles++;
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (rx_cycles % 600 == 300 || $urandom_range(0, 999) == 0) begin
			hold_left = $urandom_range(40, 120);
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(64, 512);
			end
			rx_mode_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= (rx_cycles % 7) >= 2;
			endcase
		end
	end

	// watchdog: any accepted item or register access counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// offer one tick item and hold it until accepted; in bursty mode a random
	// gap opens before each new burst
	task automatic send_tick(input logic [ECHO_W-1:0] e);
		int gap;
		if (bursty && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid    <= 1'b1;
		echo_levels <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		ticks_sent++;
	endtask

	// stop offering, wait for every result item, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// APB write of trigger_ticks after a drain: setup cycle, then access cycle
	task automatic write_ticks(input logic [TICKS_W-1:0] v);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_TRIGGER_TICKS, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		ticks_now = v;
	endtask

	// ticks needed to get from trigger start into the echo wait; zero means 256
	function automatic int min_gap();
		return (ticks_now == 0) ? 257 : int'(ticks_now) + 1;
	endfunction

	// one full measurement on the current ranger: its echo low through the
	// trigger pulse, high for pulse_len ticks, then low so the report goes out;
	// mixed puts random levels on the other rangers' echo pins
	task automatic episode(input int pulse_len, input int gap_len, input logic mixed);
		logic [ECHO_W-1:0] e;
		int                tail;
		tail = mixed ? $urandom_range(2, 4) : 2;
		repeat (gap_len) begin
			e = mixed ? ECHO_W'($urandom) : '0;
			e[ranger] = 1'b0;
			send_tick(e);
		end
		repeat (pulse_len) begin
			e = mixed ? ECHO_W'($urandom) : '1;
			e[ranger] = 1'b1;
			send_tick(e);
		end
		repeat (tail) begin
			e = mixed ? ECHO_W'($urandom) : '0;
			e[ranger] = 1'b0;
			send_tick(e);
		end
		ranger = (ranger == 2) ? '0 : ranger + 1'b1;
	endtask

	// random echo levels with no structure, then resync the ranger tracking:
	// three low ticks close any open echo, the drain settles the sequencer
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 30);
		repeat (n) send_tick(ECHO_W'($urandom));
		repeat (3) send_tick('0);
		drain();
		ranger = sensor_now;
	endtask

	// one configuration setting, then clean measurements, some after noise;
	// always ends on a clean measurement so the next phase starts at trigger
	task automatic run_phase(input logic [TICKS_W-1:0] v);
		int start;
		int plen;
		write_ticks(v);
		bursty     = ($urandom_range(0, 3) != 0);
		burst_left = 0;
		start      = ticks_sent;
		while (ticks_sent - start < PHASE_BUDGET) begin
			if ($urandom_range(0, 6) == 0)
				noise_burst();
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 600)
				: $urandom_range(1, 40);
			episode(plen, min_gap() + $urandom_range(0, 3), 1'b1);
		end
	endtask

	initial begin
		ranger     = '0;
		ticks_now  = TRIGGER_TICKS_RST;
		bursty     = 1'b0;
		burst_left = 0;
		ticks_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset value of trigger_ticks, sender never idle
		// one-tick echo gives a zero distance, echo pins all high
		episode(1, min_gap(), 1'b0);
		episode(2, min_gap(), 1'b0);
		// 58 counted ticks is exactly 1.0 cm
		episode(59, min_gap() + 2, 1'b1);

		// trigger_ticks lowered while the count is already past it: the count
		// runs on through the 8-bit wrap before the trigger drops
		bursty = 1'b1;
		write_ticks(8'd200);
		repeat (50) send_tick('0);
		write_ticks(8'd10);
		episode(20, 240, 1'b1);

		// random phases across the range of trigger_ticks, zero included
		run_phase(8'd1);
		run_phase(8'd255);
		run_phase(8'd0);
		run_phase(8'd2);
		run_phase(TICKS_W'($urandom_range(3, 20)));
		run_phase(TICKS_W'($urandom_range(1, 8)));
		run_phase(TRIGGER_TICKS_RST);

		drain();
		repeat (6) @(posedge clk);
		if (mismatch_total == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/urs_pkg.sv
rtl/core/urs_cfg.sv
rtl/core/urs_dist.sv
rtl/core/urs_seq.sv
rtl/core/ultrasonic_ranger_sequencer_top.sv
tb/ranger_checker.sv
tb/testbench.sv
